// ===== hw/rtl/size_class_slab_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Shared concurrent assertion shorthands for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH

// Plain property, checked outside reset
`define SCSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset
`define SCSA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab allocator package
// Types, constants and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package scsa_pkg;

   localparam int NUM_POOLS   = 16;
   localparam int POOL_SHIFT  = 12;             // 4096-byte pools
   localparam int SLOT_COUNT  = 256;            // slots of the smallest class
   localparam int POOL_IDX_W  = 4;
   localparam int POOL_CNT_W  = 5;
   localparam int SLOT_W      = 8;
   localparam int ADDR_W      = 17;
   localparam int SIZE_W      = 20;
   localparam int CLASS_W     = 13;
   localparam int CI_W        = 4;
   localparam int OFF_W       = 12;
   localparam int GROUP_W     = 16;
   localparam int GROUP_N     = SLOT_COUNT / GROUP_W;
   localparam logic [SIZE_W-1:0] MAX_CLASS_BYTES = 20'd4096;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_RESET = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_NO_POOL   = 3'd2,
      ST_NULL      = 3'd3,
      ST_UNKNOWN   = 3'd4,
      ST_MISALIGN  = 3'd5,
      ST_DBL_FREE  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_RDWAIT,
      S_PICK,
      S_FCHECK,
      S_RESP
   } state_type;

   // Classified request as it sits in the queue
   typedef struct packed {
      op_type             op;
      logic               bad_size;
      logic [CI_W-1:0]    ci;
      status_type         pre_status;   // early free verdict, ST_OK if none
      logic [POOL_CNT_W-1:0] pool;
      logic [OFF_W-1:0]   off;
   } item_type;

   // Queue handshake from front to back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   // Slot size in bytes of a class index
   function automatic logic [CLASS_W-1:0] class_bytes(input logic [CI_W-1:0] ci);
      class_bytes = CLASS_W'(16) << ci;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/scsa_front.sv =====
// ----------------------------------------------------------------------------
// Slab allocator front end
// Accepts requests, classifies them and holds them in a two-beat queue.
// ----------------------------------------------------------------------------
`default_nettype none
module scsa_front import scsa_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_type,
   input  wire logic [SIZE_W-1:0]   req_size,
   input  wire logic [ADDR_W-1:0]   req_address,
   output queue_out_type            q_out,
   input  wire logic                q_pop
);
   item_type         cls_item;
   item_type         entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic [CI_W-1:0]  ci;

   // Class index: smallest class that holds the size
   always_comb begin
      ci = CI_W'(8);
      for (int i = 7; i >= 0; i--) begin
         if (req_size <= (SIZE_W'(16) << i)) begin
            ci = CI_W'(i);
         end
      end
   end

   // Classify the incoming beat
   always_comb begin
      cls_item.op         = op_type'(req_type);
      cls_item.bad_size   = (req_size == '0) || (req_size > MAX_CLASS_BYTES);
      cls_item.ci         = ci;
      cls_item.pool       = req_address[ADDR_W-1:POOL_SHIFT] - POOL_CNT_W'(1);
      cls_item.off        = req_address[OFF_W-1:0];
      if (req_address == '0) begin
         cls_item.pre_status = ST_NULL;
      end else if (req_address[ADDR_W-1:POOL_SHIFT] == '0) begin
         cls_item.pre_status = ST_UNKNOWN;
      end else begin
         cls_item.pre_status = ST_OK;
      end
   end

   assign req_stall   = (count_ff == 2'd2);
   assign push        = req_valid && !req_stall;
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls_item;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/scsa_back.sv =====
// ----------------------------------------------------------------------------
// Slab allocator back end
// Walks pools, searches slot bitmaps, updates state and issues responses.
// ----------------------------------------------------------------------------
`default_nettype none
`include "size_class_slab_allocator_top_macros.svh"
module scsa_back import scsa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  queue_out_type             q_out,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_status,
   output logic [ADDR_W-1:0]         rsp_granted_address,
   output logic [CLASS_W-1:0]        rsp_granted_class
);
   state_type              state_ff, state_in;
   item_type               cur_ff, cur_in;
   logic [POOL_CNT_W-1:0]  k_ff, k_in;
   logic [POOL_CNT_W-1:0]  opened_ff, opened_in;
   logic [CI_W-1:0]        tag_ff [NUM_POOLS];
   logic                   tag_we;
   logic [POOL_IDX_W-1:0]  tag_idx;
   status_type             res_st_ff, res_st_in;
   logic [ADDR_W-1:0]      res_addr_ff, res_addr_in;
   logic [CLASS_W-1:0]     res_cls_ff, res_cls_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff;
   logic [ADDR_W-1:0]      rsp_addr_ff;
   logic [CLASS_W-1:0]     rsp_cls_ff;
   logic                   rsp_load;

   logic                   ram_we, ram_re;
   logic [POOL_IDX_W-1:0]  ram_wa, ram_ra;
   logic [SLOT_COUNT-1:0]  ram_wd, ram_rd;

   logic [SLOT_COUNT-1:0]  word_ff, word_in;
   logic [GROUP_N-1:0]     grp_any_ff, grp_any_in;
   logic [3:0]             grp_idx_ff [GROUP_N];
   logic [3:0]             grp_idx_in [GROUP_N];
   logic [SLOT_COUNT-1:0]  avail;
   logic [SLOT_W:0]        nslots;
   logic                   found;
   logic [SLOT_W-1:0]      pick_slot;

   logic [POOL_IDX_W-1:0]  fpool;
   logic [CI_W-1:0]        ftag;
   logic [CLASS_W-1:0]     fmask;
   logic [SLOT_W-1:0]      fslot;
   logic [POOL_IDX_W-1:0]  kpool;

   scsa_ram #(.WIDTH(SLOT_COUNT), .DEPTH(NUM_POOLS)) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Free decode from pool tag
   assign fpool = cur_ff.pool[POOL_IDX_W-1:0];
   assign ftag  = tag_ff[fpool];
   assign fmask = class_bytes(ftag) - CLASS_W'(1);
   assign fslot = SLOT_W'(cur_ff.off >> (ftag + CI_W'(4)));
   assign kpool = POOL_IDX_W'(k_ff - POOL_CNT_W'(1));

   // First search level: free slots in each group of sixteen
   always_comb begin
      nslots = (SLOT_W+1)'(SLOT_COUNT) >> cur_ff.ci;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         avail[i] = !ram_rd[i] && ((SLOT_W+1)'(i) < nslots);
      end
      for (int g = 0; g < GROUP_N; g++) begin
         grp_any_in[g] = |avail[g*GROUP_W +: GROUP_W];
         grp_idx_in[g] = 4'd0;
         for (int b = GROUP_W-1; b >= 0; b--) begin
            if (avail[g*GROUP_W + b]) begin
               grp_idx_in[g] = 4'(b);
            end
         end
      end
   end

   // Second search level: lowest group with a free slot
   always_comb begin
      found     = |grp_any_ff;
      pick_slot = '0;
      for (int g = GROUP_N-1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick_slot = {4'(g), grp_idx_ff[g]};
         end
      end
   end

   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      k_in        = k_ff;
      opened_in   = opened_ff;
      res_st_in   = res_st_ff;
      res_addr_in = res_addr_ff;
      res_cls_in  = res_cls_ff;
      word_in     = word_ff;
      q_pop       = 1'b0;
      tag_we      = 1'b0;
      tag_idx     = opened_ff[POOL_IDX_W-1:0];
      ram_we      = 1'b0;
      ram_wa      = kpool;
      ram_wd      = word_ff;
      ram_re      = 1'b0;
      ram_ra      = kpool;
      case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop    = 1'b1;
               cur_in   = q_out.item;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_st_in   = ST_OK;
            res_addr_in = '0;
            res_cls_in  = '0;
            state_in    = S_RESP;
            case (cur_ff.op)
               OP_ALLOC: begin
                  if (cur_ff.bad_size) begin
                     res_st_in = ST_BAD_SIZE;
                  end else begin
                     k_in     = opened_ff;
                     state_in = S_SCAN;
                  end
               end
               OP_FREE: begin
                  if (cur_ff.pre_status != ST_OK) begin
                     res_st_in = cur_ff.pre_status;
                  end else if (cur_ff.pool >= opened_ff) begin
                     res_st_in = ST_UNKNOWN;
                  end else if ((CLASS_W'(cur_ff.off) & fmask) != '0) begin
                     res_st_in = ST_MISALIGN;
                  end else begin
                     ram_re   = 1'b1;
                     ram_ra   = fpool;
                     state_in = S_FCHECK;
                  end
               end
               OP_RESET: begin
                  opened_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (k_ff == '0) begin
               state_in = S_RESP;
               if (opened_ff == POOL_CNT_W'(NUM_POOLS)) begin
                  res_st_in = ST_NO_POOL;
               end else begin
                  // Open a fresh pool with slot zero taken
                  tag_we      = 1'b1;
                  ram_we      = 1'b1;
                  ram_wa      = opened_ff[POOL_IDX_W-1:0];
                  ram_wd      = SLOT_COUNT'(1);
                  opened_in   = opened_ff + POOL_CNT_W'(1);
                  res_st_in   = ST_OK;
                  res_addr_in = ADDR_W'(opened_ff + POOL_CNT_W'(1)) << POOL_SHIFT;
                  res_cls_in  = class_bytes(cur_ff.ci);
               end
            end else if (tag_ff[kpool] == cur_ff.ci) begin
               ram_re   = 1'b1;
               state_in = S_RDWAIT;
            end else begin
               k_in = k_ff - POOL_CNT_W'(1);
            end
         end
         S_RDWAIT: begin
            word_in  = ram_rd;
            state_in = S_PICK;
         end
         S_PICK: begin
            if (found) begin
               ram_we      = 1'b1;
               ram_wd      = word_ff | (SLOT_COUNT'(1) << pick_slot);
               res_st_in   = ST_OK;
               res_addr_in = (ADDR_W'(k_ff) << POOL_SHIFT)
                           + (ADDR_W'(pick_slot) << (cur_ff.ci + CI_W'(4)));
               res_cls_in  = class_bytes(cur_ff.ci);
               state_in    = S_RESP;
            end else begin
               k_in     = k_ff - POOL_CNT_W'(1);
               state_in = S_SCAN;
            end
         end
         S_FCHECK: begin
            state_in = S_RESP;
            if (!ram_rd[fslot]) begin
               res_st_in = ST_DBL_FREE;
            end else begin
               ram_we    = 1'b1;
               ram_wa    = fpool;
               ram_wd    = ram_rd & ~(SLOT_COUNT'(1) << fslot);
               res_st_in = ST_OK;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == S_RESP && rsp_load) ||
                         (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         opened_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opened_ff    <= opened_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tags reset to class zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POOLS; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (tag_we) begin
         tag_ff[tag_idx] <= cur_ff.ci;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      k_ff        <= k_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      res_cls_ff  <= res_cls_in;
      word_ff     <= word_in;
      grp_any_ff  <= grp_any_in;
      grp_idx_ff  <= grp_idx_in;
      if (state_ff == S_RESP && rsp_load) begin
         rsp_status_ff <= res_st_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_cls_ff    <= res_cls_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_class   = rsp_cls_ff;

   // Checks
   `SCSA_ASSERT(a_opened_range, clock, reset, opened_ff <= POOL_CNT_W'(NUM_POOLS), "pool count overflow")
   `SCSA_ASSERT_IMPL(a_fail_no_addr, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_granted_address == '0 && rsp_granted_class == '0, "failed beat carries an address")
   `SCSA_ASSERT_IMPL(a_write_state, clock, reset, ram_we, state_ff == S_SCAN || state_ff == S_PICK || state_ff == S_FCHECK, "bitmap written outside an update step")
endmodule
`default_nettype wire

// ===== hw/rtl/size_class_slab_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Size-class slab allocator
// Power-of-two slab allocator over sixteen 4 KiB pools with slot bitmaps.
// ----------------------------------------------------------------------------
//   channel   ports                                     direction
//   req       req_valid/req_stall, type, size, address  in
//   rsp       rsp_valid/rsp_stall, status, addr, class  out
//
// Reset, bad size, null and rejected frees go straight from dispatch to response.
// A free that reads the bitmap does one bitmap RAM read and, unless it is a double free, one write.
// An allocate walks the pools from the last opened down, skipping pools of other
// classes and searching the RAM word of each pool of its class with the two-level
// slot search; it opens a new pool or finds none left when the walk runs out.
// reset clears control state at once; the bitmap RAM needs no clearing pass.
// A stalled response holds the back end; the front queue takes two more beats.
`default_nettype none
module size_class_slab_allocator_top import scsa_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_type,
   input  wire logic [SIZE_W-1:0]   req_size,
   input  wire logic [ADDR_W-1:0]   req_address,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [ADDR_W-1:0]        rsp_granted_address,
   output logic [CLASS_W-1:0]       rsp_granted_class
);
   queue_out_type q_out;
   logic          q_pop;

   scsa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_size    (req_size),
      .req_address (req_address),
      .q_out       (q_out),
      .q_pop       (q_pop)
   );

   scsa_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_out               (q_out),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_granted_class   (rsp_granted_class)
   );
endmodule
`default_nettype wire
